// File: src/cpdr_pkg.sv
package cpdr_pkg;

   localparam int PACKET_BYTES_DEFAULT = 16;
   localparam int SLOTS_DEFAULT        = 4;

   localparam logic [7:0] START_BYTE_RESET = 8'hAA;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic take_byte;
      logic start_read;
      logic load_byte;
      logic next_byte;
      logic load_none;
   } cmd_type;

   typedef struct packed {
      logic ring_empty;
      logic out_free;
      logic last_idx;
   } status_type;

endpackage

// File: src/cpdr_chan_if.sv
interface cpdr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface cpdr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last;
   logic       none_available;

   modport source (output valid, output packet_byte, output last, output none_available,
                   input ready);
   modport sink (input valid, input packet_byte, input last, input none_available,
                 output ready);
endinterface

interface cpdr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/cpdr_dp.sv
module cpdr_dp #(
   parameter int PACKET_BYTES = cpdr_pkg::PACKET_BYTES_DEFAULT,
   parameter int SLOTS        = cpdr_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_byte,
   input  cpdr_pkg::cmd_type    cmd,
   output cpdr_pkg::status_type status,
   cpdr_rsp_if.source           rsp_ch,
   cpdr_csr_if.sink             csr_ch
);
   import cpdr_pkg::*;

   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int IDX_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
   localparam int STORE_DEPTH = SLOTS * PACKET_BYTES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(PACKET_BYTES - 1);
   localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(PACKET_BYTES);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'b001,
      PH_DATA  = 3'b010,
      PH_CHECK = 3'b100
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [7:0]        sum_ff, sum_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [7:0]        start_byte_ff, start_byte_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_none_ff, out_none_in;

   logic [7:0]        store_mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_slot_next;
   logic [SLOT_W-1:0] oldest;
   logic              out_free;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : SLOT_W'(s + 1'b1);
   endfunction

   assign oldest       = slot_inc(rd_slot_ff);
   assign wr_slot_next = slot_inc(wr_slot_ff);
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   assign status.ring_empty = (oldest == wr_slot_ff);
   assign status.out_free   = out_free;
   assign status.last_idx   = (rd_idx_ff == LAST_IDX);

   assign csr_ch.ready = 1'b1;

   assign wr_en   = cmd.take_byte && (phase_ff == PH_DATA);
   assign wr_addr = ADDR_W'(ADDR_W'(wr_slot_ff) * ROW_SIZE + ADDR_W'(pos_ff));
   assign rd_en   = cmd.start_read || cmd.next_byte;
   assign rd_addr = cmd.start_read ? ADDR_W'(ADDR_W'(oldest) * ROW_SIZE)
                  : ADDR_W'(ADDR_W'(rd_slot_ff) * ROW_SIZE
                            + ADDR_W'(IDX_W'(rd_idx_ff + 1'b1)));

   // parser, ring pointers, read index and start byte register
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      wr_slot_in    = wr_slot_ff;
      rd_slot_in    = rd_slot_ff;
      rd_idx_in     = rd_idx_ff;
      start_byte_in = (csr_ch.valid) ? csr_ch.data : start_byte_ff;
      if (cmd.take_byte) begin
         case (phase_ff)
            PH_DATA: begin
               sum_in = sum_ff + rx_byte;
               pos_in = IDX_W'(pos_ff + 1'b1);
               if (pos_ff == LAST_IDX) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (sum_ff == rx_byte) begin
                  wr_slot_in = wr_slot_next;
                  // ring full: drop the oldest unread packet
                  if (wr_slot_next == oldest) begin
                     rd_slot_in = oldest;
                  end
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
               if (rx_byte == start_byte_ff) begin
                  phase_in = PH_DATA;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
         endcase
      end
      if (cmd.start_read) begin
         rd_slot_in = oldest;
         rd_idx_in  = '0;
      end else if (cmd.next_byte) begin
         rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_none_in  = out_none_ff;
      if (cmd.load_byte) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data_ff;
         out_last_in  = (rd_idx_ff == LAST_IDX);
         out_none_in  = 1'b0;
      end else if (cmd.load_none) begin
         out_valid_in = 1'b1;
         out_byte_in  = '0;
         out_last_in  = 1'b1;
         out_none_in  = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         pos_ff        <= '0;
         sum_ff        <= '0;
         wr_slot_ff    <= '0;
         rd_slot_ff    <= LAST_SLOT;
         rd_idx_ff     <= '0;
         start_byte_ff <= START_BYTE_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         wr_slot_ff    <= wr_slot_in;
         rd_slot_ff    <= rd_slot_in;
         rd_idx_ff     <= rd_idx_in;
         start_byte_ff <= start_byte_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_none_ff <= out_none_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.packet_byte    = out_byte_ff;
   assign rsp_ch.last           = out_last_ff;
   assign rsp_ch.none_available = out_none_ff;

endmodule

// File: src/cpdr_ctrl.sv
module cpdr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  cpdr_pkg::status_type status,
   output cpdr_pkg::cmd_type    cmd
);
   import cpdr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_NONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_READ) begin
                  if (status.ring_empty) begin
                     state_in = ST_NONE;
                  end else begin
                     cmd.start_read = 1'b1;
                     state_in       = ST_LOAD;
                  end
               end else begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            // hold the fetched byte until the output register frees up
            if (status.out_free) begin
               cmd.load_byte = 1'b1;
               if (status.last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_byte = 1'b1;
               end
            end
         end
         ST_NONE: begin
            if (status.out_free) begin
               cmd.load_none = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/checksummed_packet_deframer_ring.sv
// Deframes start-byte framed packets with an additive checksum into a ring of slots.
// req_ch carries one beat per item: kind 0 is a received byte, kind 1 asks for the
// oldest unread packet. A received byte is taken while idle, and the next beat is
// accepted in the following cycle.
// A read answers with PACKET_BYTES beats on rsp_ch (last on the final one), or one
// beat with none_available and last set when the ring holds no unread packet.
// The first read beat passes through the registered read port of the packet store
// and the output register; further beats follow one per cycle while rsp_ch does not
// stall. req_ch is held off while a read is in progress. When rsp_ch stalls, the
// output register holds its beat and the read sequence waits; received bytes are
// still accepted while a finished beat waits to be taken.
// csr_ch writes the start byte at any time it is valid (always ready); write it
// only while the block is idle.
// Reset empties the ring, sets the start byte to 0xAA and puts the parser in hunt.
// The ring keeps at most SLOTS - 1 unread packets; a good frame that fills it
// drops the oldest.
module checksummed_packet_deframer_ring #(
   parameter int PACKET_BYTES = cpdr_pkg::PACKET_BYTES_DEFAULT,
   parameter int SLOTS        = cpdr_pkg::SLOTS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   cpdr_req_if.sink    req_ch,
   cpdr_rsp_if.source  rsp_ch,
   cpdr_csr_if.sink    csr_ch
);
   import cpdr_pkg::*;

   cmd_type    cmd;
   status_type status;

   cpdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpdr_dp #(
      .PACKET_BYTES (PACKET_BYTES),
      .SLOTS        (SLOTS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .rx_byte (req_ch.rx_byte),
      .cmd     (cmd),
      .status  (status),
      .rsp_ch  (rsp_ch),
      .csr_ch  (csr_ch)
   );

   a_read_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.start_read |-> !status.ring_empty)
      else $error("read started on an empty ring");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_byte || cmd.load_none) |-> status.out_free)
      else $error("output register overwritten while holding a beat");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_byte, cmd.start_read, cmd.load_byte, cmd.load_none}))
      else $error("conflicting datapath commands");

   a_none_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.load_none |=> (rsp_ch.valid && rsp_ch.none_available && rsp_ch.last))
      else $error("empty answer not presented");

endmodule

// File: dv/tb_checksummed_packet_deframer_ring.sv
`timescale 1ns / 1ps

module tb_checksummed_packet_deframer_ring;
   import cpdr_pkg::*;

   localparam int PACKET_BYTES = PACKET_BYTES_DEFAULT;
   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT  = 150000;
   localparam int LONG_HOLD    = 400;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_SUM  = 2'd2
   } parse_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } rx_item_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last;
      logic       none_available;
   } pkt_beat_type;

   logic clock;
   logic reset;

   cpdr_req_if req_ch ();
   cpdr_rsp_if rsp_ch ();
   cpdr_csr_if csr_ch ();

   checksummed_packet_deframer_ring #(
      .PACKET_BYTES (PACKET_BYTES),
      .SLOTS        (SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // deframer state mirrored on the testbench side
   logic [7:0] sof_byte = START_BYTE_RESET;
   parse_type  parse_st = PH_HUNT;
   int         byte_pos = 0;
   logic [7:0] run_sum  = 8'h00;
   int         wr_slot  = 0;
   int         rd_slot  = SLOTS - 1;
   logic [7:0] pkt_mem [SLOTS * PACKET_BYTES];

   rx_item_type  rx_stream [$];
   pkt_beat_type readout_due [$];

   int queued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   logic hold_kick    = 1'b0;

   function automatic void deframe_step(logic kind, logic [7:0] b);
      int           oldest;
      pkt_beat_type beat;
      if (kind == KIND_BYTE) begin
         case (parse_st)
            PH_DATA: begin
               pkt_mem[wr_slot * PACKET_BYTES + byte_pos] = b;
               run_sum = run_sum + b;
               byte_pos++;
               if (byte_pos >= PACKET_BYTES) parse_st = PH_SUM;
            end
            PH_SUM: begin
               if (run_sum == b) begin
                  wr_slot = (wr_slot + 1) % SLOTS;
                  // ring full: drop the oldest unread packet
                  if (wr_slot == (rd_slot + 1) % SLOTS) rd_slot = (rd_slot + 1) % SLOTS;
               end
               parse_st = PH_HUNT;
            end
            default: begin
               parse_st = PH_HUNT;
               if (b == sof_byte) begin
                  parse_st = PH_DATA;
                  byte_pos = 0;
                  run_sum  = 8'h00;
               end
            end
         endcase
      end else begin
         oldest = (rd_slot + 1) % SLOTS;
         if (oldest == wr_slot) begin
            beat.packet_byte    = 8'h00;
            beat.last           = 1'b1;
            beat.none_available = 1'b1;
            readout_due.push_back(beat);
         end else begin
            rd_slot = oldest;
            for (int i = 0; i < PACKET_BYTES; i++) begin
               beat.packet_byte    = pkt_mem[oldest * PACKET_BYTES + i];
               beat.last           = (i == PACKET_BYTES - 1);
               beat.none_available = 1'b0;
               readout_due.push_back(beat);
            end
         end
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin : req_drive
      rx_item_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            deframe_step(req_ch.kind, req_ch.rx_byte);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = rx_stream.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.kind    <= item.kind;
               req_ch.rx_byte <= item.rx_byte;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_kick) hold_left <= LONG_HOLD;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // result monitor
   always @(posedge clock) begin : rsp_check
      pkt_beat_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (readout_due.size() == 0) begin
               $error("unexpected beat: packet_byte %0h last %0b none_available %0b",
                      rsp_ch.packet_byte, rsp_ch.last, rsp_ch.none_available);
               mismatch_count++;
            end else begin
               want = readout_due.pop_front();
               if (rsp_ch.packet_byte !== want.packet_byte) begin
                  $error("packet_byte: expected %0h, actual %0h",
                         want.packet_byte, rsp_ch.packet_byte);
                  mismatch_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_ch.last);
                  mismatch_count++;
               end
               if (rsp_ch.none_available !== want.none_available) begin
                  $error("none_available: expected %0b, actual %0b",
                         want.none_available, rsp_ch.none_available);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic add_item(logic kind, logic [7:0] b);
      rx_item_type item;
      item.kind    = kind;
      item.rx_byte = b;
      rx_stream.push_back(item);
      queued_count++;
   endtask

   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // fill: 0 random, 1 all ones, 2 all zeros; read_at places a read request
   // after that many data bytes (-1 for none)
   task automatic add_frame(logic [7:0] sof, int fill, bit corrupt, int read_at);
      logic [7:0] sum;
      logic [7:0] d;
      sum = 8'h00;
      add_item(KIND_BYTE, sof);
      for (int i = 0; i < PACKET_BYTES; i++) begin
         if (i == read_at) add_item(KIND_READ, 8'($urandom_range(255)));
         d = (fill == 1) ? 8'hFF : (fill == 2) ? 8'h00 : pick_data_byte();
         sum = sum + d;
         add_item(KIND_BYTE, d);
      end
      if (read_at == PACKET_BYTES) add_item(KIND_READ, 8'($urandom_range(255)));
      if (corrupt) sum = sum ^ (8'h01 << $urandom_range(7));
      add_item(KIND_BYTE, sum);
   endtask

   task automatic add_random_traffic(logic [7:0] sof, int n_items);
      int stop_at;
      int r;
      stop_at = queued_count + n_items;
      while (queued_count < stop_at) begin
         r = $urandom_range(99);
         if (r < 60)
            add_frame(sof, 0, ($urandom_range(99) < 15),
                      ($urandom_range(99) < 15) ? $urandom_range(PACKET_BYTES) : -1);
         else if (r < 85)
            add_item(KIND_READ, 8'($urandom_range(255)));
         else
            add_item(KIND_BYTE, 8'($urandom_range(255)));
      end
   endtask

   task automatic drain();
      while (accepted_count != queued_count || readout_due.size() != 0) @(posedge clock);
      // let a trailing read finish before touching the register
      repeat (PACKET_BYTES + 24) @(posedge clock);
   endtask

   task automatic write_start_byte(logic [7:0] v);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      sof_byte = v;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   initial begin
      logic [7:0] sof_rand;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_BYTE;
      req_ch.rx_byte = 8'h00;
      csr_ch.valid   = 1'b0;
      csr_ch.data    = 8'h00;
      rsp_ch.ready   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, noise, read inside a frame, good and bad checksum
      add_item(KIND_READ, 8'hFF);
      add_item(KIND_BYTE, 8'h00);
      add_item(KIND_BYTE, 8'h55);
      add_frame(START_BYTE_RESET, 1, 1'b0, 5);
      add_item(KIND_READ, 8'h00);
      add_frame(START_BYTE_RESET, 2, 1'b1, -1);
      add_item(KIND_READ, 8'h00);
      drain();

      write_start_byte(8'h00);
      add_random_traffic(8'h00, 32);
      drain();

      set_idling(57, 0);
      write_start_byte(8'hFF);
      add_random_traffic(8'hFF, 32);
      drain();

      set_idling(0, 57);
      sof_rand = 8'($urandom_range(1, 254));
      write_start_byte(sof_rand);
      add_random_traffic(sof_rand, 32);
      drain();

      set_idling(24, 24);
      write_start_byte(START_BYTE_RESET);
      add_random_traffic(START_BYTE_RESET, 32);
      drain();

      // hold the receiver while reads and frames keep coming
      set_idling(0, 0);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      add_frame(START_BYTE_RESET, 0, 1'b0, -1);
      add_item(KIND_READ, 8'h3C);
      add_random_traffic(START_BYTE_RESET, 28);
      drain();

      if (mismatch_count == 0 && readout_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
